[src/gaps_pkg.sv]
// Shared constants, codes and record types for the grid A* path search unit.
// Used by gaps_score and the top level; depends on nothing.
package gaps_pkg;
	// Grid geometry; GRID_W, GRID_H and TILE_SIZE must be powers of two
	localparam int GRID_W = 32;
	localparam int GRID_H = 32;
	localparam int TILE_SIZE = 16;
	localparam int CELLS = GRID_W * GRID_H;
	localparam int X_W = $clog2(GRID_W);
	localparam int Y_W = $clog2(GRID_H);
	localparam int TILE_W = X_W + Y_W;
	localparam int TILE_SH = $clog2(TILE_SIZE);

	localparam int G_W = 14;
	localparam int F_W = 15;
	localparam int STAMP_W = 11;
	localparam int CNT_W = 11;
	localparam int PCNT_W = 11;

	localparam logic [G_W-1:0] STEP_COST = 14'd10;
	localparam logic [9:0] MARGIN_RESET = 10'd120;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_FOUND = 3'd1;
	localparam logic [2:0] STAT_SAME = 3'd2;
	localparam logic [2:0] STAT_NO_PATH = 3'd3;
	localparam logic [2:0] STAT_OFF_GRID = 3'd4;
	localparam logic [2:0] STAT_BEYOND = 3'd5;

	typedef struct packed {
		logic [G_W-1:0] g;
		logic [TILE_W-1:0] parent;
		logic [STAMP_W-1:0] stamp;
		logic is_open;
		logic is_closed;
	} tile_rec_t;

	typedef struct packed {
		logic valid;
		logic [TILE_W-1:0] tile;
		logic [F_W-1:0] f;
		logic [G_W-1:0] g;
		logic [TILE_W-1:0] parent;
		logic [STAMP_W-1:0] stamp;
	} cand_t;
endpackage

[src/gaps_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gaps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/gaps_score.sv]
// Scoring stage of the open-set scan: F = G + 10 * Manhattan distance to target.
// Depends on gaps_pkg.
module gaps_score (
	input logic clk,
	input logic arst_n,
	input logic valid_s1,
	input logic [gaps_pkg::TILE_W-1:0] tile_s1,
	input gaps_pkg::tile_rec_t rec_s1,
	input logic [gaps_pkg::TILE_W-1:0] end_tile,
	output gaps_pkg::cand_t cand_s2
);
	import gaps_pkg::*;

	logic [X_W-1:0] tx, ex, dx;
	logic [Y_W-1:0] ty, ey, dy;
	logic [F_W-1:0] man, heur, f;

	always_comb begin
		tx = tile_s1[X_W-1:0];
		ty = tile_s1[TILE_W-1:X_W];
		ex = end_tile[X_W-1:0];
		ey = end_tile[TILE_W-1:X_W];
		dx = (tx > ex) ? tx - ex : ex - tx;
		dy = (ty > ey) ? ty - ey : ey - ty;
		man = F_W'(dx) + F_W'(dy);
		heur = (man << 3) + (man << 1);
		f = F_W'(rec_s1.g) + heur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_s2 <= '0;
		end else begin
			cand_s2.valid <= valid_s1 && rec_s1.is_open;
			cand_s2.tile <= tile_s1;
			cand_s2.f <= f;
			cand_s2.g <= rec_s1.g;
			cand_s2.parent <= rec_s1.parent;
			cand_s2.stamp <= rec_s1.stamp;
		end
	end
endmodule

[src/grid_astar_path_search_unit.sv]
// Top level of the grid A* path search unit: sequencer, wall map, tile and path stores.
// Depends on gaps_pkg, gaps_ram and gaps_score.
//
// Usage: commands arrive on the s_ channel (opcode in s_tuser), one result per
// command leaves on the m_ channel (status in m_tuser). Only one command is in
// work at a time; s_tready is low from the accepting transfer until its result
// has been taken on the m_ side. A stalled result simply holds.
// Sequence: a wall row load or an unused opcode answers straight from the idle
// state, a path step read after one read of the path store. A search that fails
// its position checks, or whose start and end lie in the same tile, answers at
// once; otherwise it clears the 1024-entry tile store, then for each expanded
// tile checks and updates up to four neighbors, scans the whole tile store
// through the scoring stage and makes a decision, and finally traces the path
// back step by step. The worst case is set by the single read port of the tile store.
// Reset: walls clear, top_margin 120, path empty; no clearing pass at reset. The user must
// write top_margin through cfg_we/cfg_wdata only while idle; the block does not enforce it.
module grid_astar_path_search_unit (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [9:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [87:0] s_tdata, // row_index, row_walls, start_x, start_y, end_x, end_y, step_index
	input logic [1:0] s_tuser, // opcode
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata, // path_length, direction
	output logic [2:0] m_tuser // status
);
	import gaps_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_NB_CHK = 4'd2;
	localparam logic [3:0] ST_NB_UPD = 4'd3;
	localparam logic [3:0] ST_SCAN = 4'd4;
	localparam logic [3:0] ST_DECIDE = 4'd5;
	localparam logic [3:0] ST_TRACE = 4'd6;
	localparam logic [3:0] ST_TRACE_RD = 4'd7;
	localparam logic [3:0] ST_RD_PATH = 4'd8;

	logic [3:0] state_q;
	logic [9:0] margin_q;
	logic [GRID_W-1:0] wall_q [GRID_H];
	logic [PCNT_W-1:0] path_count_q;
	logic m_tvalid_q;
	logic [2:0] status_q;
	logic [1:0] dir_q;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] iter_q;
	logic [1:0] k_q;
	logic [TILE_W-1:0] cur_q, start_q, end_q, nb_q, t_q, p_q;
	logic [G_W-1:0] g_cur_q;
	logic [STAMP_W-1:0] stamp_q;
	logic best_found_q;
	logic [F_W-1:0] best_f_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [TILE_W-1:0] best_q, best_par_q;
	logic [G_W-1:0] best_g_q;
	logic scan_v_s1;
	logic [TILE_W-1:0] scan_tile_s1;

	// input fields
	logic [1:0] in_op;
	logic [4:0] in_row;
	logic [31:0] in_walls;
	logic [9:0] in_sx, in_sy, in_ex, in_ey, in_step;
	logic accept;

	// search entry checks
	logic [9:0] stx_w, sty_w, etx_w, ety_w;
	logic pos_off;
	logic [TILE_W-1:0] start_t, end_t;

	// neighbor selection
	logic [X_W-1:0] cx, nx;
	logic [Y_W-1:0] cy, ny;
	logic nb_in, nb_ok;
	logic [TILE_W-1:0] nb_tile;
	logic [G_W-1:0] g_next;

	// stores
	logic tram_we;
	logic [TILE_W-1:0] tram_waddr, tram_raddr;
	tile_rec_t tram_wdata, tram_rdata;
	logic pram_we;
	logic [1:0] pram_wdata, pram_rdata;
	cand_t cand_s2;
	logic better;
	logic [1:0] trace_dir;

	assign in_op = s_tuser;
	assign in_row = s_tdata[4:0];
	assign in_walls = s_tdata[36:5];
	assign in_sx = s_tdata[46:37];
	assign in_sy = s_tdata[56:47];
	assign in_ex = s_tdata[66:57];
	assign in_ey = s_tdata[76:67];
	assign in_step = s_tdata[86:77];

	assign s_tready = (state_q == ST_IDLE) && !m_tvalid_q;
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tuser = status_q;
	assign m_tdata = {3'b000, dir_q, path_count_q};

	always_comb begin
		stx_w = in_sx >> TILE_SH;
		etx_w = in_ex >> TILE_SH;
		sty_w = (in_sy - margin_q) >> TILE_SH;
		ety_w = (in_ey - margin_q) >> TILE_SH;
		pos_off = (in_sy < margin_q) || (in_ey < margin_q) ||
			(stx_w >= GRID_W) || (sty_w >= GRID_H) ||
			(etx_w >= GRID_W) || (ety_w >= GRID_H);
		start_t = {sty_w[Y_W-1:0], stx_w[X_W-1:0]};
		end_t = {ety_w[Y_W-1:0], etx_w[X_W-1:0]};
	end

	// neighbor order: up, left, right, down
	always_comb begin
		cx = cur_q[X_W-1:0];
		cy = cur_q[TILE_W-1:X_W];
		nx = cx;
		ny = cy;
		nb_in = 1'b0;
		unique case (k_q)
			2'd0: begin
				ny = cy - 1'b1;
				nb_in = (cy != '0);
			end
			2'd1: begin
				nx = cx - 1'b1;
				nb_in = (cx != '0);
			end
			2'd2: begin
				nx = cx + 1'b1;
				nb_in = (cx != X_W'(GRID_W - 1));
			end
			default: begin
				ny = cy + 1'b1;
				nb_in = (cy != Y_W'(GRID_H - 1));
			end
		endcase
		nb_tile = {ny, nx};
		nb_ok = nb_in && (nb_tile != start_q) && !wall_q[ny][nx];
		g_next = g_cur_q + STEP_COST;
	end

	always_comb begin
		tram_we = 1'b0;
		tram_waddr = nb_q;
		tram_wdata = '0;
		tram_raddr = nb_tile;
		unique case (state_q)
			ST_CLEAR: begin
				tram_we = 1'b1;
				tram_waddr = cnt_q[TILE_W-1:0];
			end
			ST_NB_UPD: begin
				tram_we = !tram_rdata.is_closed &&
					(!tram_rdata.is_open || tram_rdata.g > g_next);
				tram_wdata.g = g_next;
				tram_wdata.parent = cur_q;
				tram_wdata.stamp = tram_rdata.is_open ? tram_rdata.stamp : stamp_q;
				tram_wdata.is_open = 1'b1;
			end
			ST_DECIDE: begin
				tram_we = best_found_q && (best_q != end_q);
				tram_waddr = best_q;
				tram_wdata.g = best_g_q;
				tram_wdata.parent = best_par_q;
				tram_wdata.stamp = best_stamp_q;
				tram_wdata.is_closed = 1'b1;
			end
			ST_SCAN: tram_raddr = cnt_q[TILE_W-1:0];
			ST_TRACE: tram_raddr = p_q;
			default: ;
		endcase
	end

	always_comb begin
		logic [X_W:0] tx, px;
		logic [Y_W:0] ty, py;
		tx = {1'b0, t_q[X_W-1:0]};
		px = {1'b0, p_q[X_W-1:0]};
		ty = {1'b0, t_q[TILE_W-1:X_W]};
		py = {1'b0, p_q[TILE_W-1:X_W]};
		priority if (px == tx + 1'b1) begin
			trace_dir = 2'd0;
		end else if (px + 1'b1 == tx) begin
			trace_dir = 2'd1;
		end else if (py == ty + 1'b1) begin
			trace_dir = 2'd2;
		end else begin
			trace_dir = 2'd3;
		end
	end

	assign pram_we = (state_q == ST_TRACE);
	assign pram_wdata = trace_dir;

	assign better = cand_s2.valid && (!best_found_q || cand_s2.f < best_f_q ||
		(cand_s2.f == best_f_q && cand_s2.stamp < best_stamp_q));

	gaps_ram #(.WIDTH($bits(tile_rec_t)), .DEPTH(CELLS)) u_tile_ram (
		.clk(clk),
		.we(tram_we),
		.waddr(tram_waddr),
		.wdata(tram_wdata),
		.raddr(tram_raddr),
		.rdata(tram_rdata)
	);

	gaps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_path_ram (
		.clk(clk),
		.we(pram_we),
		.waddr(cnt_q[TILE_W-1:0]),
		.wdata(pram_wdata),
		.raddr(in_step[TILE_W-1:0]),
		.rdata(pram_rdata)
	);

	gaps_score u_score (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(scan_v_s1),
		.tile_s1(scan_tile_s1),
		.rec_s1(tram_rdata),
		.end_tile(end_q),
		.cand_s2(cand_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == ST_SCAN) && (cnt_q < CNT_W'(CELLS));
		end
	end

	always_ff @(posedge clk) begin
		scan_tile_s1 <= cnt_q[TILE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			margin_q <= MARGIN_RESET;
			for (int r = 0; r < GRID_H; r++) begin
				wall_q[r] <= '0;
			end
			path_count_q <= '0;
			m_tvalid_q <= 1'b0;
			status_q <= STAT_OK;
			dir_q <= '0;
			cnt_q <= '0;
			iter_q <= '0;
			k_q <= '0;
			cur_q <= '0;
			start_q <= '0;
			end_q <= '0;
			nb_q <= '0;
			t_q <= '0;
			p_q <= '0;
			g_cur_q <= '0;
			stamp_q <= '0;
			best_found_q <= 1'b0;
			best_f_q <= '0;
			best_stamp_q <= '0;
			best_q <= '0;
			best_par_q <= '0;
			best_g_q <= '0;
		end else begin
			if (cfg_we) begin
				margin_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dir_q <= '0;
						status_q <= STAT_OK;
						m_tvalid_q <= 1'b1;
						unique case (in_op)
							OP_LOAD: begin
								if (32'(in_row) < GRID_H) begin
									wall_q[in_row[Y_W-1:0]] <= in_walls[GRID_W-1:0];
								end else begin
									status_q <= STAT_OFF_GRID;
								end
							end
							OP_SEARCH: begin
								path_count_q <= '0;
								if (pos_off) begin
									status_q <= STAT_OFF_GRID;
								end else if (start_t == end_t) begin
									end_q <= end_t;
									status_q <= STAT_SAME;
								end else begin
									m_tvalid_q <= 1'b0;
									end_q <= end_t;
									start_q <= start_t;
									cur_q <= start_t;
									g_cur_q <= '0;
									stamp_q <= '0;
									iter_q <= '0;
									cnt_q <= '0;
									state_q <= ST_CLEAR;
								end
							end
							OP_READ: begin
								if (PCNT_W'(in_step) < path_count_q) begin
									m_tvalid_q <= 1'b0;
									state_q <= ST_RD_PATH;
								end else begin
									status_q <= STAT_BEYOND;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CELLS - 1)) begin
						k_q <= '0;
						state_q <= ST_NB_CHK;
					end
				end
				ST_NB_CHK: begin
					nb_q <= nb_tile;
					if (nb_ok) begin
						state_q <= ST_NB_UPD;
					end else if (k_q == 2'd3) begin
						cnt_q <= '0;
						best_found_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_NB_UPD: begin
					if (!tram_rdata.is_closed && !tram_rdata.is_open) begin
						stamp_q <= stamp_q + 1'b1;
					end
					if (k_q == 2'd3) begin
						cnt_q <= '0;
						best_found_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= ST_NB_CHK;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (better) begin
						best_found_q <= 1'b1;
						best_f_q <= cand_s2.f;
						best_stamp_q <= cand_s2.stamp;
						best_q <= cand_s2.tile;
						best_par_q <= cand_s2.parent;
						best_g_q <= cand_s2.g;
					end
					if (cnt_q == CNT_W'(CELLS + 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					priority if (!best_found_q) begin
						status_q <= STAT_NO_PATH;
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else if (best_q == end_q) begin
						t_q <= best_q;
						p_q <= best_par_q;
						cnt_q <= '0;
						state_q <= ST_TRACE;
					end else if (iter_q == CNT_W'(CELLS - 1)) begin
						status_q <= STAT_NO_PATH;
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						iter_q <= iter_q + 1'b1;
						cur_q <= best_q;
						g_cur_q <= best_g_q;
						k_q <= '0;
						state_q <= ST_NB_CHK;
					end
				end
				ST_TRACE: begin
					cnt_q <= cnt_q + 1'b1;
					if (p_q == start_q || cnt_q == CNT_W'(CELLS - 1)) begin
						path_count_q <= PCNT_W'(cnt_q) + 1'b1;
						status_q <= STAT_FOUND;
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_TRACE_RD;
					end
				end
				ST_TRACE_RD: begin
					t_q <= p_q;
					p_q <= tram_rdata.parent;
					state_q <= ST_TRACE;
				end
				ST_RD_PATH: begin
					dir_q <= pram_rdata;
					m_tvalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		path_count_q <= PCNT_W'(CELLS))
		else $error("path count beyond grid size");

	a_stamp_range: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_q < STAMP_W'(CELLS))
		else $error("open stamp overflow");

	a_load_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_op == OP_LOAD) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("wall load did not answer in one cycle");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == ST_IDLE))
		else $error("result shown while a command is in work");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (cnt_q <= CNT_W'(CELLS + 1)))
		else $error("scan counter overran");
endmodule
